### hdl/sellp_pkg.sv
// Shared widths, register indexes and constants of the Sellmeier permittivity unit.
`default_nettype none
package sellp_pkg;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned VAL_W         = 31;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned MAX_TERMS     = 3;
  localparam int unsigned NUM_TERMS_DEF = 3;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // 2*pi scaled by 2^30, rounded
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EPS_INF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_B3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_C1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_C2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_C3 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LEN     = 3'd7;

  localparam logic signed [DATA_W-1:0] EPS_INF_RST = 32'sd65536;
  localparam logic [VAL_W-1:0]         LEN_RST     = 31'd65536;
endpackage
`default_nettype wire

### hdl/sellp_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband bits.
`default_nettype none
module sellp_div_pipe #(
  parameter int unsigned NW = 31,
  parameter int unsigned DW = 37,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);
  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] nq_q   [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [NW-1:0] nq_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   rem_sh;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in  = rem_i;
      assign den_in  = den_i;
      assign nq_in   = num_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Shift in the next dividend bit and try the subtraction
    assign rem_sh = {rem_in, nq_in[NW-1]};
    assign ge     = rem_sh >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? DW'(rem_sh - {1'b0, den_in}) : rem_sh[DW-1:0];
        nq_q[k]   <= {nq_in[NW-2:0], ge};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign quo_o  = nq_q[NW-1];
  assign side_o = side_q[NW-1];
endmodule
`default_nettype wire

### hdl/sellmeier_permittivity_unit.sv
// Top level of the fixed point three-term Sellmeier permittivity unit.
// Accepts one item per cycle while the output item is taken and returns one
// epsilon per item; each item passes through two bit-per-stage divider
// pipelines (31 stages for the frequency-to-wavelength division, 63 stages
// per term for B*C/(lambda^2 - C)). The whole pipeline holds when the output
// item is not taken. Configuration is to be written through the cfg port only
// while no item is in flight; the block itself does not enforce this.
`default_nettype none
module sellmeier_permittivity_unit #(
  parameter int unsigned NUM_TERMS = sellp_pkg::NUM_TERMS_DEF,
  parameter int unsigned FRAC_BITS = sellp_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [sellp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sellp_pkg::DATA_W-1:0]          cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  cmd_i,
  input  logic [sellp_pkg::VAL_W-1:0]           value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [sellp_pkg::DATA_W-1:0]   epsilon_o,
  output logic                                  range_error_o
);
  import sellp_pkg::*;

  localparam int unsigned DENW = VAL_W + 30 - FRAC_BITS;
  localparam int unsigned CW   = DENW + VAL_W;
  localparam int unsigned L2W  = 2 * VAL_W - FRAC_BITS;
  localparam int unsigned DSW  = L2W + 2;
  localparam int unsigned DMW  = L2W + 1;
  localparam int unsigned PW   = 2 * DATA_W - 1;
  localparam int unsigned TW   = 66;
  localparam int unsigned LAT  = 2 + VAL_W + 3 + PW + 3;
  localparam logic signed [TW-1:0] TL_POS = TW'(64'sd1 <<< 60);
  localparam logic signed [TW-1:0] TL_NEG = -TL_POS;

  // Configuration registers
  logic signed [DATA_W-1:0] eps_q;
  logic signed [DATA_W-1:0] b_q [MAX_TERMS];
  logic signed [DATA_W-1:0] c_q [MAX_TERMS];
  logic [VAL_W-1:0]         ls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_INF_RST;
      for (int i = 0; i < MAX_TERMS; i++) begin
        b_q[i] <= '0;
        c_q[i] <= '0;
      end
      ls_q <= LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_EPS_INF: eps_q  <= cfg_data_i;
        REG_TERM_B1: b_q[0] <= cfg_data_i;
        REG_TERM_B2: b_q[1] <= cfg_data_i;
        REG_TERM_B3: b_q[2] <= cfg_data_i;
        REG_TERM_C1: c_q[0] <= cfg_data_i;
        REG_TERM_C2: c_q[1] <= cfg_data_i;
        REG_TERM_C3: c_q[2] <= cfg_data_i;
        REG_LEN:     ls_q   <= cfg_data_i[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance and valid bits
  logic           en;
  logic [LAT-1:0] v_q;

  assign en          = !v_q[LAT-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], in_valid_i && en};
    end
  end

  // Stage 0: numerator product and shifted denominator
  logic             cmd0_q;
  logic [VAL_W-1:0] val0_q;
  logic [63:0]      num0_q;
  logic [DENW-1:0]  den0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd0_q <= cmd_i;
      val0_q <= value_i;
      num0_q <= TWO_PI_Q30 * 64'(ls_q);
      den0_q <= {value_i, {(30 - FRAC_BITS){1'b0}}};
    end
  end

  // Stage 1: detect a quotient beyond 31 bits, seed the divider remainder
  logic             cmd1_q;
  logic             ovf1_q;
  logic [VAL_W-1:0] val1_q;
  logic [VAL_W-1:0] nlo1_q;
  logic [DENW-1:0]  den1_q;
  logic [DENW-1:0]  rem1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd1_q <= cmd0_q;
      val1_q <= val0_q;
      ovf1_q <= CW'(num0_q) >= {den0_q, {VAL_W{1'b0}}};
      nlo1_q <= num0_q[VAL_W-1:0];
      den1_q <= den0_q;
      rem1_q <= DENW'(num0_q[63:VAL_W]);
    end
  end

  // Wavelength divider
  logic [VAL_W-1:0] lq;
  logic [VAL_W+1:0] lside;

  sellp_div_pipe #(
    .NW(VAL_W),
    .DW(DENW),
    .SW(VAL_W + 2)
  ) u_div_lambda (
    .clk_i  (clk_i),
    .en_i   (en),
    .rem_i  (rem1_q),
    .num_i  (nlo1_q),
    .den_i  (den1_q),
    .side_i ({cmd1_q, ovf1_q, val1_q}),
    .quo_o  (lq),
    .side_o (lside)
  );

  // Stage 2: pick the wavelength, clamp on overflow or zero frequency
  logic             lcmd2_q;
  logic             lerr2_q;
  logic [VAL_W-1:0] lam2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lcmd2_q <= lside[VAL_W+1];
      lerr2_q <= lside[VAL_W+1] && lside[VAL_W];
      if (!lside[VAL_W+1]) begin
        lam2_q <= lside[VAL_W-1:0];
      end else if (lside[VAL_W]) begin
        lam2_q <= '1;
      end else begin
        lam2_q <= lq;
      end
    end
  end

  // Stage 3: square the wavelength, form B*C per term
  logic [2*VAL_W-1:0]        sq;
  logic [L2W-1:0]            l2_q;
  logic                      err3_q;
  logic signed [2*DATA_W-1:0] bc3_q [NUM_TERMS];

  assign sq = (2 * VAL_W)'(lam2_q) * (2 * VAL_W)'(lam2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      l2_q   <= sq[2*VAL_W-1:FRAC_BITS];
      err3_q <= lerr2_q;
      for (int i = 0; i < NUM_TERMS; i++) begin
        bc3_q[i] <= (2 * DATA_W)'(b_q[i]) * (2 * DATA_W)'(c_q[i]);
      end
    end
  end

  // Per term: divisor, magnitudes, divider, clamp
  logic                    err4_q;
  logic signed [TW-3:0]    t5_q    [NUM_TERMS];
  logic [NUM_TERMS-1:0]    terr5;
  logic [NUM_TERMS-1:0]    perr5;

  always_ff @(posedge clk_i) begin
    if (en) begin
      err4_q <= err3_q;
    end
  end

  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_term
    logic signed [DSW-1:0] d;
    logic [PW-1:0]         nmag4_q;
    logic [DMW-1:0]        dmag4_q;
    logic                  dz4_q;
    logic                  qs4_q;
    logic [PW-1:0]         q;
    logic [2:0]            side;
    logic signed [TW-1:0]  qv;
    logic signed [TW-1:0]  tv;
    logic                  terr5_q;
    logic                  perr5_q;

    assign d = $signed({2'b00, l2_q}) - DSW'(c_q[k]);

    // Stage 4: signs and magnitudes for the divider
    always_ff @(posedge clk_i) begin
      if (en) begin
        dz4_q   <= (d == '0);
        qs4_q   <= d[DSW-1] ^ bc3_q[k][2*DATA_W-1];
        nmag4_q <= bc3_q[k][2*DATA_W-1] ? PW'(-bc3_q[k]) : PW'(bc3_q[k]);
        dmag4_q <= d[DSW-1] ? DMW'(-d) : DMW'(d);
      end
    end

    sellp_div_pipe #(
      .NW(PW),
      .DW(DMW),
      .SW(3)
    ) u_div_term (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  ('0),
      .num_i  (nmag4_q),
      .den_i  (dmag4_q),
      .side_i ({err4_q, dz4_q, qs4_q}),
      .quo_o  (q),
      .side_o (side)
    );

    assign qv = side[0] ? -TW'(q) : TW'(q);
    assign tv = TW'(b_q[k]) + qv;

    // Stage 5: term value with zero-divisor and range handling
    always_ff @(posedge clk_i) begin
      if (en) begin
        perr5_q <= side[2];
        if (side[1]) begin
          terr5_q <= 1'b1;
          if (b_q[k] == '0) begin
            t5_q[k] <= '0;
          end else if (!b_q[k][DATA_W-1]) begin
            t5_q[k] <= (TW-2)'(TL_POS);
          end else begin
            t5_q[k] <= (TW-2)'(TL_NEG);
          end
        end else if (tv > TL_POS) begin
          terr5_q <= 1'b1;
          t5_q[k] <= (TW-2)'(TL_POS);
        end else if (tv < TL_NEG) begin
          terr5_q <= 1'b1;
          t5_q[k] <= (TW-2)'(TL_NEG);
        end else begin
          terr5_q <= 1'b0;
          t5_q[k] <= (TW-2)'(tv);
        end
      end
    end

    assign terr5[k] = terr5_q;
    assign perr5[k] = perr5_q;
  end

  // Stage 6: accumulate offset and terms
  logic signed [63:0] sum;
  logic signed [63:0] acc6_q;
  logic               err6_q;

  always_comb begin
    sum = 64'(eps_q);
    for (int i = 0; i < NUM_TERMS; i++) begin
      sum = sum + 64'(t5_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      acc6_q <= sum;
      err6_q <= |terr5 || |perr5;
    end
  end

  // Stage 7: saturate to 32 bits, hold while the item waits
  logic signed [DATA_W-1:0] eps_out_q;
  logic                     err_out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (acc6_q > 64'sd2147483647) begin
        eps_out_q <= {1'b0, {(DATA_W-1){1'b1}}};
        err_out_q <= 1'b1;
      end else if (acc6_q < -64'sd2147483648) begin
        eps_out_q <= {1'b1, {(DATA_W-1){1'b0}}};
        err_out_q <= 1'b1;
      end else begin
        eps_out_q <= DATA_W'(acc6_q);
        err_out_q <= err6_q;
      end
    end
  end

  assign epsilon_o     = eps_out_q;
  assign range_error_o = err_out_q;

`ifndef SYNTH
  a_stall_holds_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[LAT-1] && !out_ready_i) |=> $stable(v_q))
    else $error("pipeline valid bits moved during a stall");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(eps_out_q) && $stable(err_out_q)))
    else $error("output item changed during a stall");

  a_wavelength_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[VAL_W+2] && !lcmd2_q) |-> !lerr2_q)
    else $error("wavelength item flagged by frequency conversion");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[0])
    else $error("accepted item did not enter the pipeline");
`endif
endmodule
`default_nettype wire
